/* rtl/core/wbps_pkg.sv */
package wbps_pkg;

  // Pattern registers always hold this many bytes, whatever the window depth.
  localparam int unsigned PatBytes = 16;
  localparam int unsigned PatW     = PatBytes * 8;
  localparam int unsigned LenW     = 5;

  // Defaults for the top level parameters.
  localparam int unsigned PatternMaxDef = 16;
  localparam int unsigned OffsetBitsDef = 32;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPatLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPatHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWildMask = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPatLen   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFirstOnly = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScanBase = 3'd5;

  // Result kinds.
  localparam logic KindMatch   = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Control from the scan logic to the window.
  typedef struct packed {
    logic accept;
    logic last;
  } win_ctrl_t;

endpackage

/* rtl/core/wbps_window.sv */
module wbps_window #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PatternMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wbps_pkg::win_ctrl_t          ctrl_i,
  input  logic [7:0]                   byte_i,
  input  logic [wbps_pkg::PatW-1:0]    pattern_i,
  input  logic [wbps_pkg::PatBytes-1:0] wild_i,
  input  logic [wbps_pkg::LenW-1:0]    len_i,
  output logic                         hit_o
);

  localparam int unsigned WinDepth =
    (PATTERN_MAX < wbps_pkg::PatBytes) ? PATTERN_MAX : wbps_pkg::PatBytes;

  logic [7:0] window_q [WinDepth];
  logic [7:0] window_d [WinDepth];

  // Window as it stands once the incoming byte is shifted in; entry 0 is newest.
  always_comb begin
    window_d[0] = byte_i;
    for (int k = 1; k < WinDepth; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  // One comparator row per possible length; the configured length picks one.
  always_comb begin
    logic row_ok;
    hit_o = 1'b0;
    for (int l = 1; l <= WinDepth; l++) begin
      row_ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (!wild_i[i] && (window_d[l-1-i] != pattern_i[i*8 +: 8])) begin
          row_ok = 1'b0;
        end
      end
      if ((len_i == wbps_pkg::LenW'(l)) && row_ok) begin
        hit_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinDepth; k++) begin
        window_q[k] <= 8'h00;
      end
    end else if (ctrl_i.accept) begin
      for (int k = 0; k < WinDepth; k++) begin
        window_q[k] <= ctrl_i.last ? 8'h00 : window_d[k];
      end
    end
  end

endmodule

/* rtl/core/wildcard_byte_pattern_scan.sv */
// Results are registered: a byte's results enter the result queue at the edge that accepts it.
// One byte per cycle while the queue has room; a byte's two results leave one at a time.
// The byte is taken while up to two earlier results wait in the four-entry queue.
// Reset (rst_ni low, asynchronous) clears the registers, the window, the counters
// and the result queue; the last byte of a region also clears the scan state.
module wildcard_byte_pattern_scan #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PatternMaxDef,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // end_of_region
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [95:0]                   m_axis_tdata,  // [63:0] match_address, [95:64] total_matches
  output logic                          m_axis_tuser,  // result_kind
  output logic                          m_axis_tlast   // final_result
);

  localparam int unsigned SeenW  = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic        kind;
    logic [63:0] addr;
    logic [31:0] count;
    logic        fin;
  } result_t;

  // Configuration registers.
  logic [wbps_pkg::PatW-1:0]     pattern_q;
  logic [wbps_pkg::PatBytes-1:0] wild_q;
  logic [wbps_pkg::LenW-1:0]     len_q;
  logic                          first_only_q;
  logic [63:0]                   base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= '0;
      wild_q       <= '0;
      len_q        <= '0;
      first_only_q <= 1'b0;
      base_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wbps_pkg::RegPatLow:    pattern_q[63:0]   <= cfg_wdata_i;
        wbps_pkg::RegPatHigh:   pattern_q[127:64] <= cfg_wdata_i;
        wbps_pkg::RegWildMask:  wild_q            <= cfg_wdata_i[15:0];
        wbps_pkg::RegPatLen:    len_q             <= cfg_wdata_i[4:0];
        wbps_pkg::RegFirstOnly: first_only_q      <= cfg_wdata_i[0];
        wbps_pkg::RegScanBase:  base_q            <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Scan state.
  logic [SeenW-1:0] seen_q, seen_d;
  logic [31:0]      cnt_q, cnt_d;
  logic             found_q;
  logic             in_acc;
  logic             win_hit;
  logic             hit;
  logic [SeenW-1:0] start;
  wbps_pkg::win_ctrl_t win_ctrl;

  assign in_acc          = s_axis_tvalid && s_axis_tready;
  assign win_ctrl.accept = in_acc;
  assign win_ctrl.last   = s_axis_tlast;

  wbps_window #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .byte_i   (s_axis_tdata),
    .pattern_i(pattern_q),
    .wild_i   (wild_q),
    .len_i    (len_q),
    .hit_o    (win_hit)
  );

  always_comb begin
    seen_d = (seen_q == {SeenW{1'b1}}) ? seen_q : seen_q + 1'b1;
    // The window only reports lengths it can hold, so a length of zero never hits.
    hit    = win_hit && (seen_d >= SeenW'(len_q)) && !(first_only_q && found_q);
    cnt_d  = (hit && (cnt_q != 32'hFFFF_FFFF)) ? cnt_q + 32'd1 : cnt_q;
    start  = seen_d - SeenW'(len_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        seen_q  <= '0;
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        seen_q  <= seen_d;
        cnt_q   <= cnt_d;
        found_q <= found_q || hit;
      end
    end
  end

  // Result queue; a match and a summary from the same byte go in together.
  result_t          q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] q_cnt_q;
  result_t          res_match, res_sum, push_a, push_b;
  logic [1:0]       push_n;
  logic             pop;

  always_comb begin
    res_match.kind  = wbps_pkg::KindMatch;
    res_match.addr  = base_q + 64'(start);
    res_match.count = cnt_d;
    res_match.fin   = !s_axis_tlast;
    res_sum.kind    = wbps_pkg::KindSummary;
    res_sum.addr    = '0;
    res_sum.count   = cnt_d;
    res_sum.fin     = 1'b1;
    push_a          = hit ? res_match : res_sum;
    push_b          = res_sum;
    push_n          = in_acc ? ({1'b0, hit} + {1'b0, s_axis_tlast}) : 2'd0;
  end

  assign s_axis_tready = (q_cnt_q <= QCntW'(QDepth - 2));
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_q + 1'b1] <= push_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      q_cnt_q  <= q_cnt_q + QCntW'(push_n) - QCntW'(pop);
    end
  end

  assign m_axis_tdata = {q_mem[rd_ptr_q].count, q_mem[rd_ptr_q].addr};
  assign m_axis_tuser = q_mem[rd_ptr_q].kind;
  assign m_axis_tlast = q_mem[rd_ptr_q].fin;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (seen_q == '0) && (cnt_q == '0) && !found_q)
    else $error("scan state not cleared at region end");

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tlast) |=> (cnt_q >= $past(cnt_q)))
    else $error("match count went down within a region");

  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (cnt_q != '0))
    else $error("found flag set with zero match count");
`endif

endmodule

/* tb/sv/tb.sv */
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandBytes = 1300;
  // No register sits at this index; a write there must change nothing.
  localparam logic [wbps_pkg::CfgIdxW-1:0] RegUnmapped = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr;
    logic [31:0] count;
    logic        fin;
  } scan_word_t;

  typedef struct packed {
    logic                         is_cfg;
    logic [wbps_pkg::CfgIdxW-1:0] idx;
    logic [63:0]                  val;
    logic [7:0]                   b;
    logic                         last;
    logic                         typed;
    scan_word_t                   word;
  } step_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [wbps_pkg::CfgIdxW-1:0] cfg_idx_i = wbps_pkg::RegPatLow;
  logic [63:0]                  cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;
  logic                         s_axis_tlast = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [95:0]                  m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;

  // Register copies and scan state as the block should hold them.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [15:0] wild = '0;
  logic [4:0]  pat_len = '0;
  logic        first_only = 1'b0;
  logic [63:0] base = '0;
  logic [7:0]  win_bytes [16] = '{default: 8'h00};
  logic [31:0] seen = '0;
  logic [31:0] hits = '0;
  logic        found = 1'b0;

  scan_word_t  pending_words [$];
  step_row_t   plan [$];
  logic        typed_on = 1'b0;
  scan_word_t  typed_word = '0;

  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  logic        hold_req = 1'b0;
  logic        gen_alph = 1'b0;
  logic [7:0]  sym_a = '0;
  logic [7:0]  sym_b = '0;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_in = 0;
  int unsigned regions_closed = 0;
  int unsigned hit_words = 0;
  int unsigned summary_words = 0;
  int unsigned reg_writes = 0;

  wildcard_byte_pattern_scan i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Shifts one byte into the window and queues the words it should cause.
  task automatic scan_byte(input logic [7:0] b, input logic last, input logic report);
    logic         hit;
    logic [127:0] pattern;
    scan_word_t   w;
    int           n;
    int           i;
    n = int'(pat_len);
    pattern = {pat_hi, pat_lo};
    for (i = 15; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (seen != '1) seen++;
    hit = (n != 0) && (n <= 16) && (seen >= 32'(n)) && !(first_only && found);
    if (hit) begin
      for (i = 0; i < n; i++) begin
        if (!wild[i] && win_bytes[n-1-i] != pattern[8*i +: 8]) hit = 1'b0;
      end
    end
    if (hit) begin
      found = 1'b1;
      if (hits != '1) hits++;
      w.kind = wbps_pkg::KindMatch;
      w.addr = base + 64'(seen - 32'(n));
      w.count = hits;
      w.fin = !last;
      if (report) pending_words = {pending_words, w};
    end
    if (last) begin
      w.kind = wbps_pkg::KindSummary;
      w.addr = '0;
      w.count = hits;
      w.fin = 1'b1;
      if (report) pending_words = {pending_words, w};
      regions_closed++;
      win_bytes = '{default: 8'h00};
      seen = '0;
      hits = '0;
      found = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    scan_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        reg_writes++;
        case (cfg_idx_i)
          wbps_pkg::RegPatLow:    pat_lo = cfg_wdata_i;
          wbps_pkg::RegPatHigh:   pat_hi = cfg_wdata_i;
          wbps_pkg::RegWildMask:  wild = cfg_wdata_i[15:0];
          wbps_pkg::RegPatLen:    pat_len = cfg_wdata_i[4:0];
          wbps_pkg::RegFirstOnly: first_only = cfg_wdata_i[0];
          wbps_pkg::RegScanBase:  base = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_in++;
        scan_byte(s_axis_tdata, s_axis_tlast, !typed_on);
        if (typed_on) pending_words = {pending_words, typed_word};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser == wbps_pkg::KindSummary) summary_words++;
        else hit_words++;
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, got kind %0b address %0h count %0d last %0b",
                   $time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tlast);
        end else begin
          want = pending_words.pop_front();
          check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
          check_field("address", want.addr, m_axis_tdata[63:0]);
          check_field("count", 64'(want.count), 64'(m_axis_tdata[95:64]));
          check_field("last", 64'(want.fin), 64'(m_axis_tlast));
        end
      end
    end
  end

  // Result side: a random stall before each word when rx_idle is set, or one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stops offering bytes until every expected word is out, then lets settle cycles pass.
  task automatic quiesce(input int settle);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_words.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [wbps_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic plan_cfg(input logic [wbps_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan = {plan, r};
  endtask

  task automatic plan_byte(input logic [7:0] b, input logic last);
    step_row_t r;
    r = '0;
    r.b = b;
    r.last = last;
    plan = {plan, r};
  endtask

  task automatic plan_word(input logic [7:0] b, input logic last, input logic kind,
                           input logic [63:0] addr, input logic [31:0] count, input logic fin);
    step_row_t r;
    r = '0;
    r.b = b;
    r.last = last;
    r.typed = 1'b1;
    r.word = '{kind: kind, addr: addr, count: count, fin: fin};
    plan = {plan, r};
  endtask

  function automatic logic [7:0] noise_byte();
    if (gen_alph) return $urandom_range(0, 1) ? sym_a : sym_b;
    return 8'($urandom);
  endfunction

  initial begin
    step_row_t    row;
    logic         in_cfg;
    logic         close;
    logic [127:0] pat_v;
    logic [63:0]  wild_v;
    logic [63:0]  len_w;
    logic [63:0]  first_w;
    logic [63:0]  base_v;
    logic [7:0]   region [$];
    int           len_v;
    int           n_phase;
    int           target;
    int           taken;
    int           chunks;
    int           cut;
    int           r;
    int           i;
    int           c;
    int           k;

    // Length zero straight after reset: only the summary comes.
    plan_byte(8'h00, 1'b0);
    plan_word(8'hFF, 1'b1, wbps_pkg::KindSummary, '0, 0, 1'b1);
    // One-byte pattern at the top of the address space; the second match wraps to zero.
    plan_cfg(wbps_pkg::RegPatLen, 64'd1);
    plan_cfg(wbps_pkg::RegScanBase, '1);
    plan_cfg(RegUnmapped, '1);
    plan_word(8'h00, 1'b0, wbps_pkg::KindMatch, '1, 1, 1'b1);
    plan_byte(8'h00, 1'b1);
    // A length above the window never matches, even with every byte a wildcard.
    plan_cfg(wbps_pkg::RegWildMask, '1);
    plan_cfg(wbps_pkg::RegPatLen, '1);
    plan_byte(8'hA5, 1'b0);
    plan_word(8'h5A, 1'b1, wbps_pkg::KindSummary, '0, 0, 1'b1);
    // First-only mode: the second instance is neither reported nor counted.
    plan_cfg(wbps_pkg::RegPatLow, 64'h0000_0000_0034_0012);
    plan_cfg(wbps_pkg::RegWildMask, 64'h0002);
    plan_cfg(wbps_pkg::RegPatLen, 64'd3);
    plan_cfg(wbps_pkg::RegFirstOnly, 64'd1);
    plan_cfg(wbps_pkg::RegScanBase, 64'h1000);
    plan_byte(8'h12, 1'b0);
    plan_byte(8'h77, 1'b0);
    plan_word(8'h34, 1'b0, wbps_pkg::KindMatch, 64'h1000, 1, 1'b1);
    plan_byte(8'h12, 1'b0);
    plan_byte(8'h00, 1'b0);
    plan_word(8'h34, 1'b1, wbps_pkg::KindSummary, '0, 1, 1'b1);
    // All wildcards: nothing until enough bytes are in, then match and summary together.
    plan_cfg(wbps_pkg::RegWildMask, 64'hFFFF);
    plan_cfg(wbps_pkg::RegPatLen, 64'd4);
    plan_cfg(wbps_pkg::RegFirstOnly, 64'd0);
    plan_cfg(wbps_pkg::RegScanBase, 64'd0);
    for (i = 1; i <= 3; i++) plan_byte(8'(i), 1'b0);
    plan_byte(8'h04, 1'b1);
    // Pattern byte from the high register behind eight wildcards.
    plan_cfg(wbps_pkg::RegPatHigh, 64'hFFFF_FFFF_FFFF_FFC3);
    plan_cfg(wbps_pkg::RegWildMask, 64'h00FF);
    plan_cfg(wbps_pkg::RegPatLen, 64'd9);
    for (i = 0; i < 8; i++) plan_byte(8'h80 >> i, 1'b0);
    plan_byte(8'hC3, 1'b1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    in_cfg = 1'b0;
    foreach (plan[j]) begin
      row = plan[j];
      if (row.is_cfg) begin
        if (!in_cfg) quiesce(4);
        in_cfg = 1'b1;
        write_reg(row.idx, row.val);
      end else begin
        if (in_cfg) cfg_we_i <= 1'b0;
        in_cfg = 1'b0;
        typed_on = row.typed;
        typed_word = row.word;
        drive_byte(row.b, row.last);
        typed_on = 1'b0;
      end
    end

    n_phase = 0;
    while (bytes_in < RandBytes + plan.size()) begin
      quiesce(4);
      r = $urandom_range(0, 19);
      if (r == 0) len_v = 0;
      else if (r == 1) len_v = 16;
      else if (r == 2) len_v = $urandom_range(17, 31);
      else if (r == 3) len_v = 15;
      else len_v = $urandom_range(1, 6);
      gen_alph = $urandom_range(0, 2) == 0;
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (i = 0; i < 16; i++) pat_v[8*i +: 8] = noise_byte();
      r = $urandom_range(0, 9);
      if (r == 0) pat_v = '0;
      else if (r == 1) pat_v = '1;
      case ($urandom_range(0, 3))
        0: wild_v = '0;
        1: wild_v = 64'($urandom & $urandom & 32'hFFFF);
        2: wild_v = 64'($urandom & 32'hFFFF);
        default: wild_v = 64'hFFFF;
      endcase
      // Bits above a register's width are sometimes set; they must be ignored.
      if ($urandom_range(0, 3) == 0) wild_v[63:16] = 48'({$urandom, $urandom});
      len_w = 64'(len_v);
      if ($urandom_range(0, 3) == 0) len_w[63:5] = 59'({$urandom, $urandom});
      first_w = 64'($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) first_w[63:1] = 63'({$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: base_v = '0;
        1: base_v = '1;
        2: base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
        default: base_v = {$urandom, $urandom};
      endcase
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      // Every byte matches here, so the result side holding off fills the block up.
      if (n_phase == 2) begin
        len_v = 1;
        len_w = 64'd1;
        wild_v = 64'h1;
        first_w = '0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      write_reg(wbps_pkg::RegPatLow, pat_v[63:0]);
      write_reg(wbps_pkg::RegPatHigh, pat_v[127:64]);
      write_reg(wbps_pkg::RegWildMask, wild_v);
      write_reg(wbps_pkg::RegPatLen, len_w);
      write_reg(wbps_pkg::RegFirstOnly, first_w);
      write_reg(wbps_pkg::RegScanBase, base_v);
      cfg_we_i <= 1'b0;
      if (n_phase == 2) hold_req = 1'b1;

      target = $urandom_range(30, 90);
      taken = 0;
      while (taken < target) begin
        region.delete();
        chunks = $urandom_range(1, 6);
        for (c = 0; c < chunks; c++) begin
          if (len_v >= 1 && len_v <= 16 && $urandom_range(0, 9) < 6) begin
            // Mostly whole instances with random wildcard bytes, sometimes cut short.
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len_v) : len_v;
            for (i = 0; i < cut; i++) begin
              region = {region, (wild_v[i] ? noise_byte() : pat_v[8*i +: 8])};
            end
          end else begin
            repeat ($urandom_range(1, 3)) region = {region, noise_byte()};
          end
        end
        // An open region carries on into the next one, or past the next settings change.
        close = $urandom_range(0, 7) != 0;
        for (k = 0; k < region.size(); k++) drive_byte(region[k], close && k == region.size() - 1);
        taken += region.size();
        if ($urandom_range(0, 7) == 0) quiesce(0);
      end
      n_phase++;
    end

    quiesce(8);
    $display("Scanned %0d bytes in %0d closed regions over %0d random settings, %0d register writes.",
             bytes_in, regions_closed, n_phase, reg_writes);
    $display("Checked %0d match words and %0d summaries with %0d mismatches.",
             hit_words, summary_words, mismatches);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/wbps_pkg.sv
rtl/core/wbps_window.sv
rtl/core/wildcard_byte_pattern_scan.sv
tb/sv/tb.sv
